/* design/ler_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the label equivalence resolver.
package ler_pkg;

    localparam int LABEL_W = 12;
    localparam int COUNT_W = 13;
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = LABEL_W + 1;

    localparam logic [MODE_W-1:0] MODE_PAIR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [LABEL_W-1:0] queried_label;
        logic [LABEL_W-1:0] root_label;
        logic               known;
        logic [COUNT_W-1:0] distinct_count;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

/* design/ler_item_if.sv */
`timescale 1ns / 1ps
// Request channel of the label equivalence resolver.
interface ler_item_if;
    import ler_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [LABEL_W-1:0] label_a;
    logic [LABEL_W-1:0] label_b;

    modport source (output valid, mode, label_a, label_b, input ready);
    modport sink   (input valid, mode, label_a, label_b, output ready);
endinterface

/* design/ler_result_if.sv */
`timescale 1ns / 1ps
// Result channel of the label equivalence resolver.
interface ler_result_if;
    import ler_pkg::*;

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] queried_label;
    logic [LABEL_W-1:0] root_label;
    logic               known;
    logic [COUNT_W-1:0] distinct_count;

    modport source (output valid, queried_label, root_label, known, distinct_count,
                    input ready);
    modport sink   (input valid, queried_label, root_label, known, distinct_count,
                    output ready);
endinterface

/* design/ler_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module ler_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/ler_seq.sv */
`timescale 1ns / 1ps
// Sequencer: clears the parent memory, marks labels, walks root chains and links roots in it.
module ler_seq #(
    parameter int LABEL_SPACE = 4096,
    localparam int AW         = (LABEL_SPACE > 1) ? $clog2(LABEL_SPACE) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    ler_item_if.sink                 item,
    input  logic                     res_free,
    output ler_pkg::result_t         res,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic [ler_pkg::ENTRY_W-1:0] mem_wdata,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr,
    input  logic [ler_pkg::ENTRY_W-1:0] mem_rdata
);
    import ler_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_CLEAR     = 7'b0000010,
        ST_MARK_RD   = 7'b0000100,
        ST_MARK_CHK  = 7'b0001000,
        ST_FIND_RD   = 7'b0010000,
        ST_FIND_STEP = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    localparam logic [AW-1:0] CLEAR_LAST = AW'(LABEL_SPACE - 1);

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [LABEL_W-1:0] a_reg, a_next;
    logic [LABEL_W-1:0] b_reg, b_next;
    logic               sel_b_reg, sel_b_next;
    logic [LABEL_W-1:0] cur_reg, cur_next;
    logic [LABEL_W-1:0] ra_reg, ra_next;
    logic [LABEL_W-1:0] root_reg, root_next;
    logic               known_reg, known_next;
    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               ent_seen;
    logic [LABEL_W-1:0] ent_up;
    logic [LABEL_W-1:0] cur_lab;
    logic               walk_done;

    function automatic logic in_space(input logic [LABEL_W-1:0] lab);
        return (32'(lab) < 32'(LABEL_SPACE));
    endfunction

    assign ent_seen  = mem_rdata[LABEL_W];
    assign ent_up    = mem_rdata[LABEL_W-1:0];
    assign cur_lab   = sel_b_reg ? b_reg : a_reg;
    assign walk_done = !ent_seen || (ent_up == cur_reg) || !in_space(ent_up);

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        sel_b_next   = sel_b_reg;
        cur_next     = cur_reg;
        ra_next      = ra_reg;
        root_next    = root_reg;
        known_next   = known_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;

        item.ready = (state_reg == ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = AW'(cur_lab);
        mem_wdata  = {1'b1, cur_lab};
        mem_re     = 1'b0;
        mem_raddr  = AW'(cur_reg);

        res.valid               = 1'b0;
        res.item.queried_label  = a_reg;
        res.item.root_label     = root_reg;
        res.item.known          = known_reg;
        res.item.distinct_count = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    mode_next  = item.mode;
                    a_next     = item.label_a;
                    b_next     = item.label_b;
                    cur_next   = item.label_a;
                    sel_b_next = 1'b0;
                    unique case (item.mode)
                        MODE_PAIR:
                        begin
                            if (in_space(item.label_a) && in_space(item.label_b))
                            begin
                                state_next = ST_MARK_RD;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (in_space(item.label_a))
                            begin
                                state_next = ST_FIND_RD;
                            end
                            else
                            begin
                                root_next  = item.label_a;
                                known_next = 1'b0;
                                state_next = ST_EMIT;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next   = '0;
                            clr_idx_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            ST_MARK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(cur_lab);
                state_next = ST_MARK_CHK;
            end
            ST_MARK_CHK:
            begin
                if (!ent_seen)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
                if (!sel_b_reg)
                begin
                    sel_b_next = 1'b1;
                    state_next = ST_MARK_RD;
                end
                else
                begin
                    sel_b_next = 1'b0;
                    cur_next   = a_reg;
                    state_next = ST_FIND_RD;
                end
            end
            ST_FIND_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_FIND_STEP;
            end
            ST_FIND_STEP:
            begin
                if (!walk_done)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ent_up);
                    cur_next  = ent_up;
                end
                else if (mode_reg == MODE_QUERY)
                begin
                    root_next  = cur_reg;
                    known_next = ent_seen;
                    state_next = ST_EMIT;
                end
                else if (!sel_b_reg)
                begin
                    ra_next    = cur_reg;
                    sel_b_next = 1'b1;
                    cur_next   = b_reg;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    // link the larger root under the smaller
                    if (ra_reg < cur_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(cur_reg);
                        mem_wdata = {1'b1, ra_reg};
                    end
                    else if (cur_reg < ra_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(ra_reg);
                        mem_wdata = {1'b1, cur_reg};
                    end
                    sel_b_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                res.valid = 1'b1;
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            sel_b_reg   <= 1'b0;
            mode_reg    <= MODE_PAIR;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            sel_b_reg   <= sel_b_next;
            mode_reg    <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        cur_reg   <= cur_next;
        ra_reg    <= ra_next;
        root_reg  <= root_next;
        known_reg <= known_next;
    end

endmodule

/* design/label_equivalence_resolver_core.sv */
`timescale 1ns / 1ps
// Top level of the label equivalence resolver: sequencer, parent memory, result register.
//
// Channels: item (mode, label_a, label_b) in, result (queried_label, root_label,
// known, distinct_count) out, both valid/ready; a request moves when both are high.
// Mode 0 declares label_a and label_b equivalent, mode 1 queries label_a, mode 2
// clears the table; mode 3 and pairs holding an out-of-range label are dropped.
// One request is worked at a time; the parent memory holds {seen, parent} per label
// with registered read data, and each step of a root walk is a read of it.
// A pair marks both labels, walks both root paths and links the two roots; a query
// walks the root path of label_a and then hands its result to the result register;
// a clear writes one memory entry per cycle.
// Out-of-range queries skip the walk and report the label as unknown. Only queries produce a result.
// Reset: the memory is swept entry by entry with item.ready low; the
// distinct count starts at zero.
// Result stall: the result register holds the answer until taken; the next
// request is still accepted, and a later query waits only for the register.
module label_equivalence_resolver_core #(
    parameter int LABEL_SPACE = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    ler_item_if.sink      item,
    ler_result_if.source  result
);
    import ler_pkg::*;

    localparam int AW = (LABEL_SPACE > 1) ? $clog2(LABEL_SPACE) : 1;

    result_t            res;
    logic               res_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    ler_seq #(
        .LABEL_SPACE (LABEL_SPACE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .res_free  (res_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ler_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LABEL_SPACE)
    ) u_parent_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_free)
        begin
            out_item_reg <= res.item;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.queried_label  = out_item_reg.queried_label;
    assign result.root_label     = out_item_reg.root_label;
    assign result.known          = out_item_reg.known;
    assign result.distinct_count = out_item_reg.distinct_count;

    a_known_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.known |-> result.distinct_count != '0)
        else $error("known label reported with zero distinct count");

    a_root_not_above: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.known |-> result.root_label <= result.queried_label)
        else $error("root larger than queried label");

    a_unknown_self: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.known |-> result.root_label == result.queried_label)
        else $error("unknown label not reported as its own root");

endmodule

/* test/tb_label_equivalence_resolver_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the label equivalence resolver: directed and random requests, predicted roots.
module tb_label_equivalence_resolver_core;
    import ler_pkg::*;

    localparam int SPACE      = 4096;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_WAIT = 9000;
    localparam int MAX_GAP    = 12;
    localparam int REQ_TARGET = 1600;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [LABEL_W-1:0] label_a;
        logic [LABEL_W-1:0] label_b;
        bit                 drain;
        bit                 quiet;
    } label_req_t;

    logic clk;
    logic rst_n;

    ler_item_if   item_ch ();
    ler_result_if result_ch ();

    label_equivalence_resolver_core #(
        .LABEL_SPACE(SPACE)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    // predictor state
    logic [LABEL_W-1:0] link_table [SPACE];
    bit                 seen_mask  [SPACE];
    logic [COUNT_W-1:0] distinct_seen;

    label_req_t pending_reqs [$];
    out_item_t  expected_roots [$];
    label_req_t live_req;
    int         total_reqs;
    int         accepted_reqs;
    int         gap_left;
    int         stall_left;
    int         fail_count;
    bit         calm;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [LABEL_W-1:0] root_of(input logic [LABEL_W-1:0] lab);
        logic [LABEL_W-1:0] cur;
        logic [LABEL_W-1:0] up;
        cur = lab;
        for (int steps = 0; steps < SPACE; steps++)
        begin
            up = link_table[cur];
            if (up == cur || int'(up) >= SPACE)
                break;
            cur = up;
        end
        return cur;
    endfunction

    task automatic note_label(input logic [LABEL_W-1:0] lab);
        if (!seen_mask[lab])
        begin
            seen_mask[lab] = 1'b1;
            link_table[lab] = lab;
            distinct_seen = distinct_seen + 1'b1;
        end
    endtask

    task automatic predict_request(input label_req_t r);
        logic [LABEL_W-1:0] ra;
        logic [LABEL_W-1:0] rb;
        out_item_t          ans;
        case (r.mode)
            MODE_PAIR:
            begin
                if (int'(r.label_a) < SPACE && int'(r.label_b) < SPACE)
                begin
                    note_label(r.label_a);
                    note_label(r.label_b);
                    ra = root_of(r.label_a);
                    rb = root_of(r.label_b);
                    if (ra < rb)
                        link_table[rb] = ra;
                    else if (rb < ra)
                        link_table[ra] = rb;
                end
            end
            MODE_QUERY:
            begin
                ans.queried_label  = r.label_a;
                ans.root_label     = r.label_a;
                ans.known          = 1'b0;
                ans.distinct_count = distinct_seen;
                if (int'(r.label_a) < SPACE && seen_mask[r.label_a])
                begin
                    ans.root_label = root_of(r.label_a);
                    ans.known      = 1'b1;
                end
                expected_roots = {expected_roots, ans};
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < SPACE; i++)
                    seen_mask[i] = 1'b0;
                distinct_seen = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_req(input logic [MODE_W-1:0] mode, input int a, input int b,
                             input bit drain = 1'b0, input bit quiet = 1'b0);
        label_req_t r;
        r.mode    = mode;
        r.label_a = a[LABEL_W-1:0];
        r.label_b = b[LABEL_W-1:0];
        r.drain   = drain;
        r.quiet   = quiet;
        pending_reqs = {pending_reqs, r};
    endtask

    // request driver
    always @(posedge clk)
    begin
        bit took;
        bit go;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            took = item_ch.valid && item_ch.ready;
            if (took)
            begin
                predict_request(live_req);
                accepted_reqs++;
                gap_left = live_req.quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (took || !item_ch.valid)
            begin
                go = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain || expected_roots.size() == 0))
                begin
                    live_req = pending_reqs.pop_front();
                    go = 1'b1;
                    item_ch.mode    <= live_req.mode;
                    item_ch.label_a <= live_req.label_a;
                    item_ch.label_b <= live_req.label_b;
                    calm            <= live_req.quiet;
                end
                item_ch.valid <= go;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_item_t want;
        bit        took;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            took = result_ch.valid && result_ch.ready;
            if (took)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected result: queried_label %0d", result_ch.queried_label);
                    fail_count++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (result_ch.queried_label !== want.queried_label)
                    begin
                        $error("queried_label: expected %0d, got %0d",
                               want.queried_label, result_ch.queried_label);
                        fail_count++;
                    end
                    if (result_ch.root_label !== want.root_label)
                    begin
                        $error("root_label: expected %0d, got %0d",
                               want.root_label, result_ch.root_label);
                        fail_count++;
                    end
                    if (result_ch.known !== want.known)
                    begin
                        $error("known: expected %0d, got %0d", want.known, result_ch.known);
                        fail_count++;
                    end
                    if (result_ch.distinct_count !== want.distinct_count)
                    begin
                        $error("distinct_count: expected %0d, got %0d",
                               want.distinct_count, result_ch.distinct_count);
                        fail_count++;
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int base;
        int chain_top;
        int chain_len;
        int a;
        int b;
        int pick;
        bit quiet;
        item_ch.valid   = 1'b0;
        item_ch.mode    = MODE_PAIR;
        item_ch.label_a = '0;
        item_ch.label_b = '0;
        result_ch.ready = 1'b0;
        calm            = 1'b0;
        distinct_seen   = '0;
        accepted_reqs   = 0;
        fail_count      = 0;
        for (int i = 0; i < SPACE; i++)
            seen_mask[i] = 1'b0;
        rst_n = 1'b0;

        // directed: extremes, self pair, unused mode, chains, clear
        queue_req(MODE_QUERY, 0, 0);
        queue_req(MODE_QUERY, 4095, 4095);
        queue_req(MODE_PAIR, 0, 4095);
        queue_req(MODE_QUERY, 4095, 0);
        queue_req(MODE_PAIR, 100, 100);
        queue_req(MODE_QUERY, 100, 4095);
        queue_req(MODE_PAIR, 4095, 'hAAA);
        queue_req(MODE_PAIR, 'h555, 'hAAA);
        queue_req(MODE_QUERY, 'h555, 0);
        queue_req(MODE_SPARE, 4095, 4095);
        queue_req(MODE_SPARE, 'h123, 'h321);
        queue_req(MODE_QUERY, 'hAAA, 'h555);
        queue_req(MODE_PAIR, 7, 5);
        queue_req(MODE_PAIR, 5, 3);
        queue_req(MODE_PAIR, 9, 7);
        queue_req(MODE_QUERY, 9, 0);
        queue_req(MODE_PAIR, 3, 4095);
        queue_req(MODE_QUERY, 9, 0);
        queue_req(MODE_QUERY, 3, 0, 1'b1);
        queue_req(MODE_CLEAR, 4095, 4095);
        queue_req(MODE_QUERY, 4095, 0);
        queue_req(MODE_QUERY, 0, 0);
        queue_req(MODE_PAIR, 4095, 0);
        queue_req(MODE_QUERY, 0, 4095);

        // random: windows of nearby labels, descending chains, some noise
        base  = 0;
        quiet = 1'b0;
        for (int n = 0; pending_reqs.size() < REQ_TARGET; n++)
        begin
            if (n % 100 == 0)
            begin
                base  = $urandom_range(0, 4095 - 63);
                quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                            : base + $urandom_range(0, 63);
            b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                            : base + $urandom_range(0, 63);
            if ($urandom_range(0, 299) == 0)
                queue_req(MODE_CLEAR, a, b, 1'b0, quiet);
            else if (pick < 4)
            begin
                chain_len = $urandom_range(4, 40);
                chain_top = $urandom_range(chain_len, 4094);
                for (int k = 0; k < chain_len; k++)
                    queue_req(MODE_PAIR, chain_top - k, chain_top - k + 1, 1'b0, quiet);
                queue_req(MODE_QUERY, chain_top + 1, b, 1'b0, quiet);
                queue_req(MODE_PAIR, chain_top - chain_len, a, 1'b0, quiet);
                queue_req(MODE_QUERY, chain_top + 1, a, 1'b0, quiet);
            end
            else if (pick < 7)
                queue_req(MODE_SPARE, a, b, 1'b0, quiet);
            else if (pick < 58)
                queue_req(MODE_PAIR, a, b, 1'b0, quiet);
            else
                queue_req(MODE_QUERY, a, b, (n % 400 == 200), quiet);
        end
        total_reqs = pending_reqs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || expected_roots.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_roots.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/ler_pkg.sv
design/ler_item_if.sv
design/ler_result_if.sv
design/ler_ram.sv
design/ler_seq.sv
design/label_equivalence_resolver_core.sv
test/tb_label_equivalence_resolver_core.sv
